// ----- hw/rtl/mwbf_pkg.sv -----
// Shared constants, codes and control structs for the mailbox receive FIFO.
`timescale 1ns / 1ps

package mwbf_pkg;

  localparam int FIFO_DEPTH_DEF = 128;

  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int LEVEL_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int CNT_LSB     = 24;
  localparam int CNT_W       = 2;
  localparam int SPARE_MIN   = 3;
  localparam int OUT_DATA_W  = 24;

  localparam logic OP_POST = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STS_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STS_BUSY     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_BYTE     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 2'd3;

  typedef struct packed {
    logic             load;
    logic             push;
    logic [CNT_W-1:0] sel;
    logic             rd;
    logic             fin;
  } mwbf_cmd_t;

  typedef struct packed {
    logic stalled;
    logic out_free;
  } mwbf_sts_t;

endpackage

// ----- hw/rtl/mwbf_ctrl.sv -----
// Controller state machine: sequences byte pushes, store reads and result hand-off.
`timescale 1ns / 1ps

module mwbf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_op,
  input  logic [mwbf_pkg::CNT_W-1:0] in_cnt,
  input  mwbf_pkg::mwbf_sts_t       sts,
  output mwbf_pkg::mwbf_cmd_t       cmd
);
  import mwbf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          n_nxt    = in_cnt;
          idx_nxt  = '0;
          if (in_op == OP_READ) begin
            state_nxt = ST_READ;
          end else if (!sts.stalled && in_cnt != '0) begin
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        cmd.sel  = idx_r;
        if (idx_r == n_r - CNT_W'(1)) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.push, cmd.rd, cmd.fin}))
    else $error("controller issued more than one command");

  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (idx_r < n_r || idx_r == n_r - CNT_W'(1)))
    else $error("push index beyond byte count");

  a_read_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> (state_r == ST_FIN))
    else $error("store read not followed by finish");

endmodule

// ----- hw/rtl/mwbf_dp.sv -----
// Datapath: byte store, pointers, level, stall flag and result register.
`timescale 1ns / 1ps

module mwbf_dp #(
  parameter int DEPTH = mwbf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mwbf_pkg::mwbf_cmd_t           cmd,
  output mwbf_pkg::mwbf_sts_t           sts,
  input  logic                          in_op,
  input  logic [mwbf_pkg::WORD_W-1:0]   in_word,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mwbf_pkg::STATUS_W-1:0] out_status,
  output logic [mwbf_pkg::BYTE_W-1:0]   out_data,
  output logic [mwbf_pkg::LEVEL_W-1:0]  out_level,
  output logic                          out_full
);
  import mwbf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] STALL_LVL = CW'(DEPTH - SPARE_MIN);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic              op_r;
  logic [WORD_W-1:0] word_r;
  logic [BYTE_W-1:0] rdata_r;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              stalled_r, stalled_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic              full_r;

  logic [BYTE_W-1:0] push_byte;
  logic              pop;
  logic [CW-1:0]     cnt_after;

  assign sts.stalled  = stalled_r;
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    case (cmd.sel)
      2'd0:    push_byte = word_r[7:0];
      2'd1:    push_byte = word_r[15:8];
      2'd2:    push_byte = word_r[23:16];
      default: push_byte = '0;
    endcase
  end

  always_comb begin
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    stalled_nxt   = stalled_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    level_nxt     = level_r;
    out_valid_nxt = out_valid_r && !out_tready;
    pop           = (op_r == OP_READ) && (count_r != '0);
    cnt_after     = pop ? count_r - CW'(1) : count_r;

    if (cmd.push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      count_nxt  = count_r + CW'(1);
    end

    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
      data_nxt      = '0;
      count_nxt     = cnt_after;
      level_nxt     = LEVEL_W'(cnt_after);
      if (op_r == OP_POST) begin
        if (stalled_r) begin
          status_nxt = STS_BUSY;
        end else begin
          status_nxt  = STS_ACCEPTED;
          stalled_nxt = (cnt_after >= STALL_LVL);
        end
      end else begin
        if (pop) begin
          status_nxt = STS_BYTE;
          data_nxt   = rdata_r;
          rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
        end else begin
          status_nxt = STS_EMPTY;
        end
        if (stalled_r && cnt_after < STALL_LVL) begin
          stalled_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_ptr_r] <= push_byte;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      word_r <= in_word;
    end
    status_r <= status_nxt;
    data_r   <= data_nxt;
    level_r  <= level_nxt;
    if (cmd.fin) begin
      full_r <= stalled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      stalled_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      stalled_r   <= stalled_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = status_r;
  assign out_data   = data_r;
  assign out_level  = level_r;
  assign out_full   = full_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> count_r < DEPTH_CNT)
    else $error("push into a full byte store");

  a_stall_level: assert property (@(posedge clk) disable iff (!rst_n)
    stalled_r |-> count_r >= STALL_LVL)
    else $error("stall held with room for a full post");

  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken beat");

endmodule

// ----- hw/rtl/mailbox_word_to_byte_fifo_top.sv -----
// An accepted post of n bytes (n = 0..3) pushes them into the byte store in order,
// one byte per cycle through its single write port, then hands off its result beat;
// a read reads the store, then hands off; a refused post goes straight to the hand-off.
// A new word is taken only in idle, once the result of the last one has been registered.
// Reset (rst_n low, synchronous) empties the FIFO, clears the stall and the
// output beat; the byte store itself is not cleared.
`timescale 1ns / 1ps

module mailbox_word_to_byte_fifo_top #(
  parameter int FIFO_DEPTH = mwbf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mwbf_pkg::WORD_W-1:0]     in_tdata,   // [31:0] mail_word
  input  logic                            in_tuser,   // [0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mwbf_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] data_byte, [15:8] fifo_level,
                                                      // [16] mailbox_full, [23:17] zero
  output logic [mwbf_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);
  import mwbf_pkg::*;

  mwbf_cmd_t          cmd;
  mwbf_sts_t          sts;
  logic [BYTE_W-1:0]  data_byte;
  logic [LEVEL_W-1:0] fifo_level;
  logic               mailbox_full;

  mwbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_cnt    (in_tdata[CNT_LSB +: CNT_W]),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwbf_dp #(
    .DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_word    (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_data   (data_byte),
    .out_level  (fifo_level),
    .out_full   (mailbox_full)
  );

  assign out_tdata = {7'd0, mailbox_full, fifo_level, data_byte};

endmodule

// ----- sim/mailbox_word_to_byte_fifo_top_tb.sv -----
// Self-checking testbench for the mailbox receive byte FIFO: directed table, then random traffic.
`timescale 1ns / 1ps

module mailbox_word_to_byte_fifo_top_tb;
  import mwbf_pkg::*;

  localparam int DEPTH      = FIFO_DEPTH_DEF;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int PHASE_LEN  = 390;
  localparam int DRAIN_WAIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] sts;
    logic [BYTE_W-1:0]   data;
    logic [LEVEL_W-1:0]  lvl;
    logic                full;
  } mb_result_t;

  typedef struct {
    logic       op;
    logic [31:0] word;
    int         rep;
    bit         typed;
    mb_result_t want;
  } mb_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata = '0;
  logic                  in_tuser = OP_POST;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // predictor state
  logic [BYTE_W-1:0]  fifo_mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] fifo_count;
  logic               rx_stalled;

  mb_result_t pending_results[$];
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int errors = 0;
  int n_posts = 0, n_reads = 0, n_busy = 0, n_empty = 0, n_stalls = 0;

  mailbox_word_to_byte_fifo_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic mb_result_t mailbox_step(input logic op, input logic [31:0] word);
    mb_result_t r;
    logic [CNT_W-1:0] nbytes;
    logic was_stalled;
    r = '0;
    was_stalled = rx_stalled;
    if (op == OP_POST) begin
      n_posts++;
      if (rx_stalled) begin
        r.sts = STS_BUSY;
        n_busy++;
      end else begin
        nbytes = word[CNT_LSB +: CNT_W];
        for (int i = 0; i < nbytes; i++) begin
          if (fifo_count < DEPTH) begin
            fifo_mem[PTR_W'((rd_ptr + fifo_count) % DEPTH)] = word[i*8 +: 8];
            fifo_count++;
          end
        end
        if (DEPTH - fifo_count <= SPARE_MIN) rx_stalled = 1'b1;
        r.sts = STS_ACCEPTED;
      end
    end else begin
      n_reads++;
      if (fifo_count == 0) begin
        r.sts = STS_EMPTY;
        n_empty++;
      end else begin
        r.data = fifo_mem[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        fifo_count--;
        r.sts = STS_BYTE;
      end
      if (rx_stalled && (DEPTH - fifo_count > SPARE_MIN)) rx_stalled = 1'b0;
    end
    if (!was_stalled && rx_stalled) n_stalls++;
    r.lvl  = fifo_count;
    r.full = rx_stalled;
    return r;
  endfunction

  task automatic send_beat(input logic op, input logic [31:0] word, input bit typed,
                           input mb_result_t want);
    mb_result_t got;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = mailbox_step(op, word);
    pending_results.push_back(typed ? want : got);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    mb_result_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected beat sts=%0d tdata=%h", out_tuser, out_tdata);
      end else begin
        w = pending_results.pop_front();
        if (out_tuser !== w.sts || out_tdata[7:0] !== w.data || out_tdata[15:8] !== w.lvl ||
            out_tdata[16] !== w.full || out_tdata[23:17] !== 7'd0) begin
          errors++;
          if (errors <= 10)
            $display({"ERROR: beat mismatch exp sts=%0d data=%h lvl=%0d full=%0d, ",
                      "got sts=%0d data=%h lvl=%0d full=%0d pad=%h"},
                     w.sts, w.data, w.lvl, w.full, out_tuser, out_tdata[7:0],
                     out_tdata[15:8], out_tdata[16], out_tdata[23:17]);
        end
      end
    end
  end

  mb_row_t dir_rows[$];

  function automatic mb_row_t mk_row(input logic op, input logic [31:0] word, input int rep,
                                     input bit typed, input logic [1:0] sts,
                                     input logic [7:0] data, input logic [7:0] lvl,
                                     input logic full);
    mb_row_t r;
    r.op    = op;
    r.word  = word;
    r.rep   = rep;
    r.typed = typed;
    r.want  = '{sts: sts, data: data, lvl: lvl, full: full};
    return r;
  endfunction

  initial begin
    mb_result_t none;
    int post_pct;
    int seg_left;
    int guard;
    logic op;
    logic [31:0] word;
    none = '0;
    rd_ptr = '0;
    fifo_count = '0;
    rx_stalled = 1'b0;

    // empty reads, zero count, byte order, bit 31 ignored, fill to stall, refused posts, drain
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_EMPTY,    8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'hFCFF_FFFF, 1,   1, STS_ACCEPTED, 8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h03A5_5AC3, 1,   1, STS_ACCEPTED, 8'h00, 8'd3,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_BYTE,     8'hC3, 8'd2,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_BYTE,     8'h5A, 8'd1,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_BYTE,     8'hA5, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'hFFFF_FFFF, 1,   1, STS_EMPTY,    8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h0100_00FF, 1,   1, STS_ACCEPTED, 8'h00, 8'd1,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h0200_FF00, 1,   1, STS_ACCEPTED, 8'h00, 8'd3,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'hFFFF_FFFF, 1,   1, STS_ACCEPTED, 8'h00, 8'd6,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 6,   0, STS_BYTE,     8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_EMPTY,    8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h03C0_FFEE, 41,  0, STS_ACCEPTED, 8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h0312_3456, 1,   1, STS_ACCEPTED, 8'h00, 8'd126, 1'b1));
    dir_rows.push_back(mk_row(OP_POST, 32'hFFFF_FFFF, 1,   1, STS_BUSY,     8'h00, 8'd126, 1'b1));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   0, STS_BYTE,     8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   0, STS_BYTE,     8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h0000_0000, 1,   1, STS_ACCEPTED, 8'h00, 8'd124, 1'b0));
    dir_rows.push_back(mk_row(OP_POST, 32'h0100_00AB, 1,   1, STS_ACCEPTED, 8'h00, 8'd125, 1'b1));
    dir_rows.push_back(mk_row(OP_POST, 32'h0300_0000, 1,   1, STS_BUSY,     8'h00, 8'd125, 1'b1));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   0, STS_BYTE,     8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 124, 0, STS_BYTE,     8'h00, 8'd0,   1'b0));
    dir_rows.push_back(mk_row(OP_READ, 32'h0000_0000, 1,   1, STS_EMPTY,    8'h00, 8'd0,   1'b0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].rep)
        send_beat(dir_rows[r].op, dir_rows[r].word, dir_rows[r].typed, dir_rows[r].want);
    end

    // random traffic in bursts that fill the FIFO, drain it, or hover near the stall point
    seg_left = 0;
    post_pct = 50;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(120, 40);
          case ($urandom_range(2))
            0: post_pct = 85;
            1: post_pct = 50;
            default: post_pct = 15;
          endcase
        end
        seg_left--;
        op = ($urandom_range(99) < post_pct) ? OP_POST : OP_READ;
        word = $urandom;
        if ($urandom_range(3) == 0) word[CNT_LSB +: CNT_W] = 2'd3;
        send_beat(op, word, 0, none);
      end
    end
    in_tvalid <= 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;

    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_WAIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("ERROR: %0d results never arrived", pending_results.size());
    end

    $display("Covered %0d posts (%0d refused as busy), %0d reads (%0d on empty FIFO),",
             n_posts, n_busy, n_reads, n_empty);
    $display("%0d stall episodes over four idling mixes; %0d mismatches", n_stalls, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mwbf_pkg.sv
hw/rtl/mwbf_ctrl.sv
hw/rtl/mwbf_dp.sv
hw/rtl/mailbox_word_to_byte_fifo_top.sv
sim/mailbox_word_to_byte_fifo_top_tb.sv
